// ===== design/goahm_pkg.sv =====
// ----------------------------------------------------------------------------
// goahm_pkg: shared types and constants for the grouped hash map
// Beat payload structs, action and status codes, control byte markers,
// controller command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none
package goahm_pkg;

  localparam int KeyW   = 64;
  localparam int ValW   = 32;
  localparam int CountW = 11;
  localparam int TagW   = 7;

  // actions
  localparam logic [1:0] ACT_SEARCH  = 2'd0;
  localparam logic [1:0] ACT_INS_ABS = 2'd1;
  localparam logic [1:0] ACT_INS_REP = 2'd2;
  localparam logic [1:0] ACT_DELETE  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_KEPT     = 3'd3;
  localparam logic [2:0] ST_REPLACED = 3'd4;
  localparam logic [2:0] ST_DELETED  = 3'd5;
  localparam logic [2:0] ST_FULL     = 3'd6;

  // control byte markers
  localparam logic [7:0] CTRL_EMPTY   = 8'hFF;
  localparam logic [7:0] CTRL_DELETED = 8'h80;

  localparam logic [CountW-1:0] COUNT_MAX = 11'd2047;

  // register addresses
  localparam logic [0:0] REG_ACTIVE_LOG2 = 1'b0;

  typedef struct packed {
    logic [1:0]      action;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ValW-1:0]   value_out;
    logic [CountW-1:0] entry_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request, start hashing
    logic hash_step;  // advance one hash stage
    logic grp_start;  // set group to start group, clear probe counters
    logic grp_read;   // issue read of current group
    logic grp_eval;   // evaluate read group
    logic grp_next;   // step to next group
    logic fr_start;   // restart at start group for free search
    logic commit;     // perform update and build result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;        // key found in evaluated group
    logic has_empty;  // evaluated group holds an empty slot
    logic has_free;   // evaluated group holds an empty or deleted slot
    logic last_grp;   // evaluated group is the last allowed in the probe
    logic clr_done;   // clearing pass finished
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== design/goahm_ctrl.sv =====
// ----------------------------------------------------------------------------
// goahm_ctrl: operation sequencer
// Steps each beat through hashing, the lookup probe, the free slot probe for
// inserts of absent keys, and the commit, then holds the result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module goahm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire logic [1:0]         action,
  output goahm_pkg::dp_cmd_t      cmd,
  input  wire goahm_pkg::dp_sts_t sts
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HASH1 = 4'd2;
  localparam logic [3:0] S_HASH2 = 4'd3;
  localparam logic [3:0] S_LREAD = 4'd4;
  localparam logic [3:0] S_LEVAL = 4'd5;
  localparam logic [3:0] S_FREAD = 4'd6;
  localparam logic [3:0] S_FEVAL = 4'd7;
  localparam logic [3:0] S_COMMIT = 4'd8;
  localparam logic [3:0] S_HOLD  = 4'd9;
  localparam logic [3:0] S_HASH3 = 4'd10;
  localparam logic [3:0] S_HASH4 = 4'd11;
  localparam logic [3:0] S_HASH5 = 4'd12;

  logic [3:0] state, state_next;
  logic [1:0] act;
  logic       need_free;

  // action of the beat in flight
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action;
    end
  end

  assign need_free = (act == goahm_pkg::ACT_INS_ABS) ||
                     (act == goahm_pkg::ACT_INS_REP);
  assign in_stall  = (state != S_IDLE);

  // output holding flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: if (sts.clr_done) state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_HASH1;
        end
      end
      S_HASH1: begin
        cmd.hash_step = 1'b1;
        state_next    = S_HASH2;
      end
      S_HASH2: begin
        cmd.hash_step = 1'b1;
        state_next    = S_HASH3;
      end
      S_HASH3: begin
        cmd.hash_step = 1'b1;
        state_next    = S_HASH4;
      end
      S_HASH4: begin
        cmd.hash_step = 1'b1;
        state_next    = S_HASH5;
      end
      S_HASH5: begin
        cmd.hash_step = 1'b1;
        cmd.grp_start = 1'b1;
        state_next    = S_LREAD;
      end
      S_LREAD: begin
        cmd.grp_read = 1'b1;
        state_next   = S_LEVAL;
      end
      S_LEVAL: begin
        cmd.grp_eval = 1'b1;
        if (sts.hit || sts.has_empty || sts.last_grp) begin
          if (!sts.hit && need_free) begin
            cmd.fr_start = 1'b1;
            state_next   = S_FREAD;
          end else begin
            state_next = S_COMMIT;
          end
        end else begin
          cmd.grp_next = 1'b1;
          state_next   = S_LREAD;
        end
      end
      S_FREAD: begin
        cmd.grp_read = 1'b1;
        state_next   = S_FEVAL;
      end
      S_FEVAL: begin
        if (sts.has_free || sts.last_grp) begin
          state_next = S_COMMIT;
        end else begin
          cmd.grp_next = 1'b1;
          state_next   = S_FREAD;
        end
      end
      S_COMMIT: begin
        // wait until the result register is free or being emptied
        if (!out_valid || !out_stall) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_HOLD:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/goahm_dp.sv =====
// ----------------------------------------------------------------------------
// goahm_dp: hash map datapath
// Multi-cycle key mixer, group-wide control byte, key and value memories,
// probe bookkeeping, live entry count and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module goahm_dp #(
  parameter int GROUPS     = 64,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire goahm_pkg::req_t    req,
  input  wire logic [2:0]         active_log2,
  input  wire goahm_pkg::dp_cmd_t cmd,
  output goahm_pkg::dp_sts_t      sts,
  output goahm_pkg::rsp_t         rsp
);

  localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int SLOTS = 16;
  localparam int MAXLOG = $clog2(GROUPS + 1) - 1;
  localparam logic [63:0] M1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] M2 = 64'hc4ceb9fe1a85ec53;

  typedef logic [SLOTS-1:0][7:0]            ctrl_row_t;
  typedef logic [SLOTS-1:0][KEY_BITS-1:0]   key_row_t;
  typedef logic [SLOTS-1:0][VALUE_BITS-1:0] val_row_t;

  // one row per group, all slots side by side
  ctrl_row_t ctrl_mem [GROUPS];
  key_row_t  key_mem  [GROUPS];
  val_row_t  val_mem  [GROUPS];

  logic [1:0]            r_action;
  logic [KEY_BITS-1:0]   r_key;
  logic [VALUE_BITS-1:0] r_value;
  logic [63:0]           h;
  logic [63:0]           hx;
  logic [63:0]           mul_m;
  logic [63:0]           p_lo;
  logic [31:0]           p_cross;
  logic [2:0]            hstage;
  logic [6:0]            tag;
  logic [GW-1:0]         grp, start_grp, mask;
  logic [GW:0]           visited;
  logic [GW:0]           n_active;
  logic [GW:0]           clr_addr;
  logic                  clearing;
  ctrl_row_t             rd_ctrl;
  key_row_t              rd_key;
  val_row_t              rd_val;
  logic [GW-1:0]         rd_grp;
  logic [SLOTS-1:0]      m_hit, m_empty, m_free;
  logic [3:0]            hit_slot, free_slot;
  logic                  hit_any, empty_any, free_any;
  logic                  f_hit, f_empty, f_free;
  logic [GW-1:0]         f_grp;
  logic [3:0]            f_slot, fr_slot;
  logic [GW-1:0]         fr_grp;
  logic [goahm_pkg::CountW-1:0] live;
  logic [2:0]            eff_log2;

  // active group count, saturated to the table size
  always_comb begin
    eff_log2 = (32'(active_log2) > MAXLOG) ? 3'(MAXLOG) : active_log2;
    n_active = (GW+1)'(1) << eff_log2;
    mask     = GW'(n_active - (GW+1)'(1));
  end

  // shift-xor of the running hash and the multiplier for this round
  assign hx    = h ^ (h >> 33);
  assign mul_m = (hstage == 3'd0) ? M1 : M2;

  // key mixer: each 64-bit multiply is split into 32 by 32 partial
  // products, which are registered and then summed into the running hash
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_action <= req.action;
      r_key    <= req.key[KEY_BITS-1:0];
      r_value  <= VALUE_BITS'(req.value);
      h        <= 64'(req.key[KEY_BITS-1:0]);
      hstage   <= 3'd0;
    end else if (cmd.hash_step) begin
      hstage <= hstage + 3'd1;
      unique case (hstage)
        3'd0, 3'd2: begin
          p_lo    <= 64'(hx[31:0]) * 64'(mul_m[31:0]);
          p_cross <= hx[63:32] * mul_m[31:0] + hx[31:0] * mul_m[63:32];
        end
        3'd1, 3'd3: h <= p_lo + {p_cross, 32'd0};
        default:    h <= hx;
      endcase
    end
  end

  // probe position: start group and visited count
  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
    end else if (cmd.grp_start) begin
      start_grp <= GW'(((h ^ (h >> 33)) >> 7)) & mask;
      grp       <= GW'(((h ^ (h >> 33)) >> 7)) & mask;
      tag       <= 7'(h ^ (h >> 33));
      visited   <= '0;
    end else if (cmd.fr_start) begin
      grp     <= start_grp;
      visited <= '0;
    end else if (cmd.grp_next) begin
      grp     <= (grp + GW'(1)) & mask;
      visited <= visited + (GW+1)'(1);
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      clr_addr <= clr_addr + (GW+1)'(1);
      if (clr_addr == (GW+1)'(GROUPS - 1)) clearing <= 1'b0;
    end
  end

  // group read, registered
  always_ff @(posedge clk) begin
    if (cmd.grp_read) begin
      rd_ctrl <= ctrl_mem[grp];
      rd_key  <= key_mem[grp];
      rd_val  <= val_mem[grp];
      rd_grp  <= grp;
    end
  end

  // slot match vectors
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      m_hit[s]   = (rd_ctrl[s] == {1'b0, tag}) && (rd_key[s] == r_key);
      m_empty[s] = (rd_ctrl[s] == goahm_pkg::CTRL_EMPTY);
      m_free[s]  = rd_ctrl[s][7];
    end
    hit_slot  = '0;
    free_slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (m_hit[s])  hit_slot  = 4'(s);
      if (m_free[s]) free_slot = 4'(s);
    end
    hit_any   = |m_hit;
    empty_any = |m_empty;
    free_any  = |m_free;
  end

  assign sts.hit       = hit_any;
  assign sts.has_empty = empty_any;
  assign sts.has_free  = free_any;
  assign sts.last_grp  = (visited == n_active - (GW+1)'(1));
  assign sts.clr_done  = !clearing;

  // lookup and free slot outcome
  always_ff @(posedge clk) begin
    if (cmd.grp_start) begin
      f_hit  <= 1'b0;
      f_free <= 1'b0;
    end else if (cmd.grp_eval) begin
      f_hit   <= hit_any;
      f_empty <= empty_any;
      f_grp   <= rd_grp;
      f_slot  <= hit_slot;
    end else if (!cmd.grp_read && !cmd.grp_next && !f_free && free_any
                 && !f_hit && !cmd.commit && !cmd.fr_start && !cmd.load
                 && !cmd.hash_step) begin
      f_free  <= 1'b1;
      fr_grp  <= rd_grp;
      fr_slot <= free_slot;
    end
  end

  // memory writes, commit and result
  always_ff @(posedge clk) begin
    if (clearing) begin
      ctrl_mem[clr_addr[GW-1:0]] <= {SLOTS{goahm_pkg::CTRL_EMPTY}};
    end else if (cmd.commit) begin
      if (f_hit && r_action == goahm_pkg::ACT_DELETE) begin
        ctrl_mem[f_grp][f_slot] <= f_empty ? goahm_pkg::CTRL_EMPTY
                                           : goahm_pkg::CTRL_DELETED;
      end else if (!f_hit && f_free && live < goahm_pkg::COUNT_MAX &&
                   (r_action == goahm_pkg::ACT_INS_ABS ||
                    r_action == goahm_pkg::ACT_INS_REP)) begin
        ctrl_mem[fr_grp][fr_slot] <= {1'b0, tag};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (f_hit && r_action == goahm_pkg::ACT_INS_REP) begin
        val_mem[f_grp][f_slot] <= r_value;
      end else if (!f_hit && f_free && live < goahm_pkg::COUNT_MAX &&
                   (r_action == goahm_pkg::ACT_INS_ABS ||
                    r_action == goahm_pkg::ACT_INS_REP)) begin
        key_mem[fr_grp][fr_slot] <= r_key;
        val_mem[fr_grp][fr_slot] <= r_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (cmd.commit) begin
      if (f_hit && r_action == goahm_pkg::ACT_DELETE) begin
        if (live != '0) live <= live - 1'b1;
      end else if (!f_hit && f_free && live < goahm_pkg::COUNT_MAX &&
                   (r_action == goahm_pkg::ACT_INS_ABS ||
                    r_action == goahm_pkg::ACT_INS_REP)) begin
        live <= live + 1'b1;
      end
    end
  end

  assign rsp.entry_count = live;

  logic [2:0]  o_status;
  logic [31:0] o_value;
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      o_value <= '0;
      unique case (r_action)
        goahm_pkg::ACT_SEARCH: begin
          o_status <= f_hit ? goahm_pkg::ST_FOUND : goahm_pkg::ST_NOTFOUND;
          if (f_hit) o_value <= 32'(rd_val[f_slot]);
        end
        goahm_pkg::ACT_DELETE:
          o_status <= f_hit ? goahm_pkg::ST_DELETED : goahm_pkg::ST_NOTFOUND;
        goahm_pkg::ACT_INS_ABS: begin
          if (f_hit) begin
            o_status <= goahm_pkg::ST_KEPT;
            o_value  <= 32'(rd_val[f_slot]);
          end else begin
            o_status <= (f_free && live < goahm_pkg::COUNT_MAX) ?
                        goahm_pkg::ST_INSERTED : goahm_pkg::ST_FULL;
          end
        end
        default: begin
          if (f_hit) o_status <= goahm_pkg::ST_REPLACED;
          else o_status <= (f_free && live < goahm_pkg::COUNT_MAX) ?
                           goahm_pkg::ST_INSERTED : goahm_pkg::ST_FULL;
        end
      endcase
    end
  end
  assign rsp.status    = o_status;
  assign rsp.value_out = o_value;

  // visited count never passes the active group count
  assert property (@(posedge clk) disable iff (rst) visited <= n_active)
    else $error("probe ran past active groups");
  // a commit never comes during the clearing pass
  assert property (@(posedge clk) disable iff (rst) cmd.commit |-> !clearing)
    else $error("commit during clear");
  // live count stays within range
  assert property (@(posedge clk) disable iff (rst)
    live <= goahm_pkg::COUNT_MAX) else $error("live count overflow");

endmodule
`default_nettype wire

// ===== design/grouped_open_address_hash_map_unit.sv =====
// ----------------------------------------------------------------------------
// grouped_open_address_hash_map_unit: grouped open address hash map
// Fixed capacity key/value map, 16 slots per group, linear group probing.
// ----------------------------------------------------------------------------
// One beat at a time: an operation occupies the block through key mixing, a
// group read and evaluate per group in the lookup probe, and, for inserts of
// absent keys, a group read and evaluate per group in the free slot probe,
// then the commit. Key mixing splits each 64-bit multiply into 32 by 32
// partial products. The result is held in an output register until taken;
// the next beat may be taken meanwhile, but its commit waits for that register.
// After reset a clearing pass over all GROUPS groups runs before the first beat.
`default_nettype none
module grouped_open_address_hash_map_unit #(
  parameter int GROUPS     = 64,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire goahm_pkg::req_t  in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output goahm_pkg::rsp_t       out_data,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [0:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  goahm_pkg::dp_cmd_t cmd;
  goahm_pkg::dp_sts_t sts;
  logic [2:0]         active_log2;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      active_log2 <= 3'd6;
    end else if (psel && penable && pwrite &&
                 paddr == goahm_pkg::REG_ACTIVE_LOG2) begin
      active_log2 <= pwdata[2:0];
    end
  end
  assign prdata = (paddr == goahm_pkg::REG_ACTIVE_LOG2) ? {29'd0, active_log2} : 32'd0;

  goahm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .action(in_data.action), .cmd, .sts
  );

  goahm_dp #(.GROUPS(GROUPS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk, .rst, .req(in_data), .active_log2, .cmd, .sts, .rsp(out_data)
  );

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the grouped open address hash map
// Random and directed map operations checked against a behavioural copy of
// the map kept in the bench, over several active group counts.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;

  localparam int NGRP  = 64;
  localparam int NSLOT = NGRP * 16;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  goahm_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  goahm_pkg::rsp_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [0:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  grouped_open_address_hash_map_unit #(.GROUPS(NGRP)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // shadow copy of the map
  logic [7:0]  map_ctrl [NSLOT];
  logic [63:0] map_key [NSLOT];
  logic [31:0] map_val [NSLOT];
  int unsigned map_live;
  logic [2:0]  map_log2;

  goahm_pkg::req_t pending_q [$];
  goahm_pkg::rsp_t expected_q [$];
  logic [63:0] key_pool [$];
  int errors = 0;
  int n_sent = 0;
  int n_got = 0;
  int idle_cycles = 0;
  int in_gap = 0;
  int out_gap = 0;
  int st_seen [7];

  function automatic logic [63:0] murmur_mix(logic [63:0] k);
    k = k ^ (k >> 33);
    k = k * 64'hff51afd7ed558ccd;
    k = k ^ (k >> 33);
    k = k * 64'hc4ceb9fe1a85ec53;
    k = k ^ (k >> 33);
    return k;
  endfunction

  function automatic int unsigned groups_in_use();
    int unsigned n;
    n = 1 << map_log2;
    while (n > NGRP) n = n >> 1;
    return n;
  endfunction

  function automatic bit grp_has_empty(int unsigned g);
    for (int s = 0; s < 16; s++)
      if (map_ctrl[g*16+s] == goahm_pkg::CTRL_EMPTY) return 1'b1;
    return 1'b0;
  endfunction

  // apply one operation to the shadow map and return the result it gives
  function automatic goahm_pkg::rsp_t map_apply(goahm_pkg::req_t r);
    goahm_pkg::rsp_t o;
    logic [63:0] h;
    logic [6:0] tag;
    int unsigned n, mask, g, slot;
    bit found, had_empty, got_free, emp;
    h = murmur_mix(r.key);
    tag = h[6:0];
    n = groups_in_use();
    mask = n - 1;
    found = 1'b0;
    had_empty = 1'b0;
    slot = 0;
    g = 32'((h >> 7) & 64'(mask));
    for (int i = 0; i < n && !found; i++) begin
      emp = grp_has_empty(g);
      for (int s = 0; s < 16; s++)
        if (!found && map_ctrl[g*16+s] == {1'b0, tag} && map_key[g*16+s] == r.key) begin
          found = 1'b1;
          slot = g*16+s;
          had_empty = emp;
        end
      if (!found && emp) break;
      g = (g + 1) & mask;
    end
    o = '0;
    case (r.action)
      goahm_pkg::ACT_SEARCH: begin
        o.status = found ? goahm_pkg::ST_FOUND : goahm_pkg::ST_NOTFOUND;
        if (found) o.value_out = map_val[slot];
      end
      goahm_pkg::ACT_DELETE: begin
        if (found) begin
          map_ctrl[slot] = had_empty ? goahm_pkg::CTRL_EMPTY : goahm_pkg::CTRL_DELETED;
          if (map_live > 0) map_live--;
          o.status = goahm_pkg::ST_DELETED;
        end else begin
          o.status = goahm_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        if (found && r.action == goahm_pkg::ACT_INS_ABS) begin
          o.status = goahm_pkg::ST_KEPT;
          o.value_out = map_val[slot];
        end else if (found) begin
          map_val[slot] = r.value;
          o.status = goahm_pkg::ST_REPLACED;
        end else begin
          got_free = 1'b0;
          g = 32'((h >> 7) & 64'(mask));
          for (int i = 0; i < n && !got_free; i++) begin
            for (int s = 0; s < 16; s++)
              if (!got_free && map_ctrl[g*16+s][7]) begin
                got_free = 1'b1;
                slot = g*16+s;
              end
            g = (g + 1) & mask;
          end
          if (map_live >= goahm_pkg::COUNT_MAX || !got_free) begin
            o.status = goahm_pkg::ST_FULL;
          end else begin
            map_key[slot] = r.key;
            map_val[slot] = r.value;
            map_ctrl[slot] = {1'b0, tag};
            map_live++;
            o.status = goahm_pkg::ST_INSERTED;
          end
        end
      end
    endcase
    o.entry_count = map_live[10:0];
    return o;
  endfunction

  // input driver: one beat per queued item after a random gap
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(map_apply(in_data));
        n_sent++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled beat
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_q.size() > 0) begin
        in_data <= pending_q.pop_front();
        in_valid <= 1'b1;
        in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output monitor and random stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_got++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          errors++;
        end else begin
          goahm_pkg::rsp_t e;
          e = expected_q.pop_front();
          st_seen[e.status]++;
          if (e.status != out_data.status)
            $display("%0t: status expected %0d actual %0d", $time, e.status,
                     out_data.status);
          if (e.value_out != out_data.value_out)
            $display("%0t: value_out expected %h actual %h", $time, e.value_out,
                     out_data.value_out);
          if (e.entry_count != out_data.entry_count)
            $display("%0t: entry_count expected %0d actual %0d", $time, e.entry_count,
                     out_data.entry_count);
          if (e != out_data) errors++;
        end
        out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on beats in either direction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired, %0d sent %0d received", n_sent, n_got);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic reg_write(logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= goahm_pkg::REG_ACTIVE_LOG2; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    map_log2 = v[2:0];
  endtask

  function automatic logic [63:0] rand_key();
    logic [63:0] k;
    case ($urandom_range(0, 4))
      0: k = '0;
      1: k = '1;
      default: k = {$urandom(), $urandom()};
    endcase
    return k;
  endfunction

  task automatic push_op(logic [1:0] a, logic [63:0] k, logic [31:0] v);
    goahm_pkg::req_t r;
    r.action = a; r.key = k; r.value = v;
    pending_q.push_back(r);
  endtask

  // random phase over a small pool of keys so hits, deletes and full happen
  task automatic random_phase(int n_ops, int pool_sz);
    logic [63:0] k;
    key_pool.delete();
    for (int i = 0; i < pool_sz; i++) key_pool.push_back(rand_key());
    for (int i = 0; i < n_ops; i++) begin
      if ($urandom_range(0, 9) == 0) k = rand_key();
      else k = key_pool[$urandom_range(0, pool_sz - 1)];
      push_op(2'($urandom_range(0, 3)), k, (i % 7 == 0) ? '1 : $urandom());
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      map_ctrl[i] = goahm_pkg::CTRL_EMPTY;
      map_key[i] = '0;
      map_val[i] = '0;
    end
    map_live = 0;
    map_log2 = 3'd6;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes and every action
    push_op(goahm_pkg::ACT_SEARCH, 64'd0, 32'd0);
    push_op(goahm_pkg::ACT_DELETE, 64'd0, 32'd0);
    push_op(goahm_pkg::ACT_INS_ABS, 64'd0, 32'hFFFF_FFFF);
    push_op(goahm_pkg::ACT_INS_ABS, 64'd0, 32'h1234_5678);
    push_op(goahm_pkg::ACT_SEARCH, 64'd0, 32'd0);
    push_op(goahm_pkg::ACT_INS_REP, 64'd0, 32'd0);
    push_op(goahm_pkg::ACT_INS_REP, '1, 32'hFFFF_FFFF);
    push_op(goahm_pkg::ACT_SEARCH, '1, 32'd0);
    push_op(goahm_pkg::ACT_DELETE, '1, 32'd0);
    push_op(goahm_pkg::ACT_DELETE, '1, 32'd0);
    push_op(goahm_pkg::ACT_SEARCH, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
    push_op(goahm_pkg::ACT_INS_ABS, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
    wait_drained();

    // two groups: fill past capacity for full status and tombstones
    reg_write(32'd1);
    for (int i = 0; i < 40; i++)
      push_op(goahm_pkg::ACT_INS_ABS, {$urandom(), $urandom()}, $urandom());
    wait_drained();
    random_phase(150, 40);
    wait_drained();

    // zero gives one group, seven saturates to all groups
    reg_write(32'd0);
    random_phase(120, 24);
    wait_drained();
    reg_write(32'd7);
    random_phase(200, 120);
    wait_drained();
    reg_write(32'd3);
    random_phase(200, 80);
    wait_drained();
    reg_write(32'd6);
    random_phase(240, 200);

    wait_drained();
    $display("ran %0d operations over group counts 1 to 64", n_got);
    $display("status counts: %p", st_seen);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
design/goahm_pkg.sv
design/goahm_ctrl.sv
design/goahm_dp.sv
design/grouped_open_address_hash_map_unit.sv
test/tb_top.sv
